>>> rtl/core/sibd_pkg.sv
package sibd_pkg;

  localparam int unsigned MaxBase    = 16;
  localparam int unsigned DigitSlots = 32;
  localparam int unsigned PcW        = 3;
  localparam int unsigned SlotW      = $clog2(DigitSlots);
  localparam int unsigned CountW     = SlotW + 1;

  localparam logic [7:0] SymPlus  = 8'h2B;
  localparam logic [7:0] SymMinus = 8'h2D;

  typedef enum logic [1:0] {
    REG_BASE_LEN     = 2'd0,
    REG_SYMBOLS_LOW  = 2'd1,
    REG_SYMBOLS_HIGH = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIVB,
    DP_PUSH,
    DP_SIGN,
    DP_DIGIT
  } dp_op_e;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_NO_GO,
    CND_BYTE_MORE,
    CND_QUOT_NZ,
    CND_OUT_BUSY,
    CND_MORE_DIGITS
  } cond_e;

  typedef struct packed {
    dp_op_e           op;
    cond_e            cond;
    logic [PcW-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic no_go;
    logic byte_more;
    logic quot_nz;
    logic out_busy;
    logic more_digits;
  } flags_t;

  localparam logic [PcW-1:0] PcIdle  = 3'd0;
  localparam logic [PcW-1:0] PcDiv   = 3'd1;
  localparam logic [PcW-1:0] PcPush  = 3'd2;
  localparam logic [PcW-1:0] PcSign  = 3'd3;
  localparam logic [PcW-1:0] PcDigit = 3'd4;
  localparam logic [PcW-1:0] PcDone  = 3'd5;

  // control store: on a true condition jump to target, else fall through
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      PcIdle:  w = '{op: DP_LOAD,  cond: CND_NO_GO,       target: PcIdle};
      PcDiv:   w = '{op: DP_DIVB,  cond: CND_BYTE_MORE,   target: PcDiv};
      PcPush:  w = '{op: DP_PUSH,  cond: CND_QUOT_NZ,     target: PcDiv};
      PcSign:  w = '{op: DP_SIGN,  cond: CND_OUT_BUSY,    target: PcSign};
      PcDigit: w = '{op: DP_DIGIT, cond: CND_MORE_DIGITS, target: PcDigit};
      PcDone:  w = '{op: DP_NOP,   cond: CND_ALWAYS,      target: PcIdle};
      default: w = '{op: DP_NOP,   cond: CND_ALWAYS,      target: PcIdle};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/signed_int_to_base_digits_core.sv
// Converts one signed 32-bit request into its symbol run in the configured base:
// a '-' for negatives, then the digits most significant first, looked up in the
// symbol table, with tlast on the final symbol. A request is taken only while
// the sequencer sits in its idle step. A request seen while the base is invalid
// (base_len below 2 or above 16, a repeated symbol, or '+' or '-' among the used
// symbols) is consumed and yields nothing. Otherwise each digit of a request
// takes four steps of the shared divider, which retires eight quotient bits a
// cycle, plus one push step; then one sign step, one cycle per digit symbol
// while the output is not stalled, and one return step.
// The output register lets the next symbol be formed in the cycle the waiting
// one is taken, so an always-ready receiver sees one symbol per cycle.
module signed_int_to_base_digits_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value (signed)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] symbol
  output logic        m_axis_tlast
);

  logic [4:0]   base_len_q;
  logic [127:0] sym_tab_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_len_q <= '0;
      sym_tab_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sibd_pkg::REG_BASE_LEN:     base_len_q       <= cfg_data_i[4:0];
        sibd_pkg::REG_SYMBOLS_LOW:  sym_tab_q[63:0]  <= cfg_data_i;
        sibd_pkg::REG_SYMBOLS_HIGH: sym_tab_q[127:64] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // base check: all pairs compared side by side
  logic base_ok;
  always_comb begin
    base_ok = (base_len_q >= 5'd2) && (base_len_q <= 5'(sibd_pkg::MaxBase));
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < base_len_q) begin
        if (sym_tab_q[i*8 +: 8] == sibd_pkg::SymPlus ||
            sym_tab_q[i*8 +: 8] == sibd_pkg::SymMinus) begin
          base_ok = 1'b0;
        end
        for (int j = i + 1; j < 16; j++) begin
          if (5'(j) < base_len_q && sym_tab_q[j*8 +: 8] == sym_tab_q[i*8 +: 8]) begin
            base_ok = 1'b0;
          end
        end
      end
    end
  end

  sibd_pkg::uword_t uw;
  sibd_pkg::flags_t flags;

  sibd_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uw)
  );

  logic [31:0]                 mag_q, mag_d;
  logic                        neg_q, neg_d;
  logic [3:0]                  rem_q, rem_d;
  logic [1:0]                  byte_q, byte_d;
  logic [sibd_pkg::CountW-1:0] count_q, count_d;
  logic [3:0]                  stack_q [sibd_pkg::DigitSlots];
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  out_sym_q, out_sym_d;
  logic                        out_last_q, out_last_d;

  logic                        go, out_busy, push, emit;
  logic [sibd_pkg::SlotW-1:0]  top_idx;
  logic [3:0]                  top_q;
  logic [3:0]                  div_rem;
  logic [7:0]                  div_q;
  logic [4:0]                  trial;

  assign s_axis_tready = (uw.op == sibd_pkg::DP_LOAD);
  assign go            = s_axis_tvalid && s_axis_tready && base_ok;
  assign out_busy      = out_valid_q && !m_axis_tready;
  // top of stack as it will stand next cycle
  assign top_idx       = count_d[sibd_pkg::SlotW-1:0] - 1'b1;

  assign flags.no_go       = !(s_axis_tvalid && base_ok);
  assign flags.byte_more   = (byte_q != 2'd3);
  assign flags.quot_nz     = (mag_q != '0);
  assign flags.out_busy    = out_busy;
  assign flags.more_digits = out_busy || (count_q != sibd_pkg::CountW'(1));

  // eight restoring steps on the 5-bit partial remainder
  always_comb begin
    div_rem = rem_q;
    div_q   = '0;
    for (int k = 0; k < 8; k++) begin
      trial = {div_rem, mag_q[31-k]};
      if (trial >= base_len_q) begin
        div_rem     = 4'(trial - base_len_q);
        div_q[7-k]  = 1'b1;
      end else begin
        div_rem = trial[3:0];
      end
    end
  end

  always_comb begin
    mag_d      = mag_q;
    neg_d      = neg_q;
    rem_d      = rem_q;
    byte_d     = byte_q;
    count_d    = count_q;
    push       = 1'b0;
    emit       = 1'b0;
    out_sym_d  = out_sym_q;
    out_last_d = out_last_q;
    unique case (uw.op)
      sibd_pkg::DP_LOAD: begin
        if (go) begin
          neg_d   = s_axis_tdata[31];
          mag_d   = s_axis_tdata[31] ? (32'd0 - s_axis_tdata) : s_axis_tdata;
          rem_d   = '0;
          byte_d  = '0;
          count_d = '0;
        end
      end
      sibd_pkg::DP_DIVB: begin
        mag_d  = {mag_q[23:0], div_q};
        rem_d  = div_rem;
        byte_d = byte_q + 1'b1;
      end
      sibd_pkg::DP_PUSH: begin
        push    = 1'b1;
        count_d = count_q + 1'b1;
        rem_d   = '0;
      end
      sibd_pkg::DP_SIGN: begin
        if (!out_busy && neg_q) begin
          emit       = 1'b1;
          out_sym_d  = sibd_pkg::SymMinus;
          out_last_d = 1'b0;
        end
      end
      sibd_pkg::DP_DIGIT: begin
        if (!out_busy) begin
          emit       = 1'b1;
          out_sym_d  = sym_tab_q[{top_q, 3'b000} +: 8];
          out_last_d = (count_q == sibd_pkg::CountW'(1));
          count_d    = count_q - 1'b1;
        end
      end
      default: ;
    endcase
    out_valid_d = emit || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q       <= '0;
      neg_q       <= 1'b0;
      rem_q       <= '0;
      byte_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      rem_q       <= rem_d;
      byte_q      <= byte_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[count_q[sibd_pkg::SlotW-1:0]] <= rem_q;
    end
    top_q <= stack_q[top_idx];
    if (emit) begin
      out_sym_q  <= out_sym_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sym_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sibd_pkg::CountW'(sibd_pkg::DigitSlots))
    else $error("digit count beyond stack depth");

  a_rem_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == sibd_pkg::DP_DIVB) |-> (rem_q < base_len_q))
    else $error("partial remainder not below radix");

  a_idle_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (byte_q == 2'd0))
    else $error("divider byte counter not at zero when idle");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (uw.op == sibd_pkg::DP_DIGIT) && (count_q == sibd_pkg::CountW'(1)))
    |=> (out_last_q && (count_q == '0)))
    else $error("final digit left stack non-empty or unmarked");
`endif

endmodule

>>> rtl/core/sibd_seq.sv
module sibd_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sibd_pkg::flags_t  flags_i,
  output sibd_pkg::uword_t  uword_o
);

  logic [sibd_pkg::PcW-1:0] pc_q, pc_d;
  sibd_pkg::uword_t         uw;
  logic                     take;

  assign uw      = sibd_pkg::ucode(pc_q);
  assign uword_o = uw;

  always_comb begin
    unique case (uw.cond)
      sibd_pkg::CND_ALWAYS:      take = 1'b1;
      sibd_pkg::CND_NO_GO:       take = flags_i.no_go;
      sibd_pkg::CND_BYTE_MORE:   take = flags_i.byte_more;
      sibd_pkg::CND_QUOT_NZ:     take = flags_i.quot_nz;
      sibd_pkg::CND_OUT_BUSY:    take = flags_i.out_busy;
      sibd_pkg::CND_MORE_DIGITS: take = flags_i.more_digits;
      default:                   take = 1'b1;
    endcase
    pc_d = take ? uw.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= sibd_pkg::PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
